// ----- src/cmvn_pkg.sv -----
// Shared types, constants and helpers for the cepstral mean/variance normalizer.
// No dependencies; every other file refers to it by scoped names.
package cmvn_pkg;

    localparam int DIM_MAX = 64;
    localparam int DIM_W   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

    localparam int QDEPTH = 4;
    localparam int QW     = $clog2(QDEPTH);

    localparam int DIV_W     = 66;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int SQRT_STEPS = 32;

    localparam logic [31:0] ONE_COUNT = 32'd4096;
    localparam logic signed [66:0] VAR_CAP = 67'sd140737488355328;
    localparam logic [31:0] M16_MAX = 32'h7FFF_FFFF;

    localparam logic CFG_SCALE_EN = 1'b0;
    localparam logic CFG_REVERSE  = 1'b1;

    typedef enum logic [1:0] {
        K_ACC   = 2'd0,
        K_APPLY = 2'd1,
        K_FAKE  = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LOW   = 2'd1,
        ST_FLOOR = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic               dim_ok;
        logic [5:0]         dim;
        logic signed [15:0] feature;
        logic [15:0]        weight;
    } t_cmd;

    typedef struct packed {
        logic scale_en;
        logic reverse;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } t_div_req;

    // Sign and magnitude to saturated Q8.8.
    function automatic logic [15:0] sat16(input logic neg, input logic [DIV_W-1:0] mag);
        logic [15:0] res;
        if (neg) begin
            if (mag > DIV_W'(32768)) res = 16'h8000;
            else                     res = 16'(~mag[15:0] + 16'd1);
        end else begin
            if (mag > DIV_W'(32767)) res = 16'h7FFF;
            else                     res = mag[15:0];
        end
        return res;
    endfunction

endpackage

// ----- src/cmvn_front.sv -----
// Front end: takes input beats, classifies them and queues them for the back end.
// Depends on cmvn_pkg.
module cmvn_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_kind,
    input  logic [5:0]           i_dim_index,
    input  logic signed [15:0]   i_feature,
    input  logic [15:0]          i_weight,
    output cmvn_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_pop
);

    cmvn_pkg::t_cmd r_q [cmvn_pkg::QDEPTH];
    logic [cmvn_pkg::QW-1:0] r_wr_ptr, r_rd_ptr;
    logic [cmvn_pkg::QW:0]   r_count;
    logic push, pop;
    cmvn_pkg::t_cmd cmd_in;

    assign o_in_stall  = (r_count == (cmvn_pkg::QW+1)'(cmvn_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && o_cmd_valid;
    assign o_cmd = r_q[r_rd_ptr];

    always_comb begin
        cmd_in.kind    = cmvn_pkg::t_kind'(i_kind);
        cmd_in.dim_ok  = (32'(i_dim_index) < cmvn_pkg::DIM_MAX);
        cmd_in.dim     = i_dim_index;
        cmd_in.feature = i_feature;
        cmd_in.weight  = i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= cmd_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- src/cmvn_div.sv -----
// Radix-4 restoring divider, 66-bit dividend by 32-bit divisor, two bits a cycle.
// Depends on cmvn_pkg.
module cmvn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmvn_pkg::t_div_req            i_req,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [cmvn_pkg::DIV_W-1:0]    o_quot
);

    logic [cmvn_pkg::DIV_W-1:0] r_dq;
    logic [31:0] r_rem, r_div;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [32:0] t1, t2;
    logic        ge1, ge2;
    logic [31:0] rem1, rem2;

    always_comb begin
        t1   = {r_rem, r_dq[cmvn_pkg::DIV_W-1]};
        ge1  = (t1 >= {1'b0, r_div});
        rem1 = ge1 ? 32'(t1 - {1'b0, r_div}) : t1[31:0];
        t2   = {rem1, r_dq[cmvn_pkg::DIV_W-2]};
        ge2  = (t2 >= {1'b0, r_div});
        rem2 = ge2 ? 32'(t2 - {1'b0, r_div}) : t2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dq  <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[cmvn_pkg::DIV_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(cmvn_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

// ----- src/cmvn_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// Depends on cmvn_pkg.
module cmvn_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_v;
    logic [31:0] r_root;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [35:0] rem_s, trial;
    logic        ge;

    always_comb begin
        rem_s = {r_rem, r_v[63:62]};
        trial = {2'b00, r_root, 2'b01};
        ge    = (rem_s >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[61:0], 2'b00};
            r_root <= {r_root[30:0], ge};
            r_rem  <= ge ? 34'(rem_s - trial) : rem_s[33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(cmvn_pkg::SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/cmvn_back.sv -----
// Back end: statistics store, accumulate/fake/clear updates and the apply sequencer.
// Depends on cmvn_pkg; drives the shared divider and square-root units.
module cmvn_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmvn_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_pop,
    input  cmvn_pkg::t_cfg                i_cfg,
    output cmvn_pkg::t_div_req            o_div_req,
    input  logic                          i_div_done,
    input  logic [cmvn_pkg::DIV_W-1:0]    i_div_quot,
    output logic                          o_sqrt_start,
    output logic [63:0]                   o_sqrt_value,
    input  logic                          i_sqrt_done,
    input  logic [31:0]                   i_sqrt_root,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_norm_value,
    output logic [5:0]                    o_out_dim_index,
    output logic [1:0]                    o_status
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_READ = 15'b000000000000010,
        S_DISP = 15'b000000000000100,
        S_MUL1 = 15'b000000000001000,
        S_MUL2 = 15'b000000000010000,
        S_ACC  = 15'b000000000100000,
        S_MEAN = 15'b000000001000000,
        S_MO   = 15'b000000010000000,
        S_MSQ  = 15'b000000100000000,
        S_E2   = 15'b000001000000000,
        S_VAR  = 15'b000010000000000,
        S_SD   = 15'b000100000000000,
        S_SDX  = 15'b001000000000000,
        S_REV  = 15'b010000000000000,
        S_FWD  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin;

    // statistics store
    logic signed [47:0] mem_sv [cmvn_pkg::DIM_MAX];
    logic [63:0]        mem_sq [cmvn_pkg::DIM_MAX];
    logic [cmvn_pkg::DIM_MAX-1:0] r_valid;
    logic signed [47:0] r_sv_rd;
    logic [63:0]        r_sq_rd;
    logic               r_vld_rd;
    logic [31:0]        r_count;

    cmvn_pkg::t_cmd     r_cmd;
    logic signed [31:0] r_m16;
    logic [46:0]        r_msq;
    logic signed [32:0] r_p1;
    logic [31:0]        r_xx;
    logic [47:0]        r_p2;
    logic [31:0]        r_sd;
    logic [47:0]        r_var;
    logic signed [48:0] r_prod;
    logic               r_neg;
    logic [15:0]        r_res;
    logic [1:0]         r_res_status;

    logic                      r_out_valid;
    logic [15:0]               r_out_value;
    logic [5:0]                r_out_dim;
    logic [1:0]                r_out_status;

    logic [cmvn_pkg::DIM_W-1:0] addr;
    logic signed [47:0] sv;
    logic [63:0]        sq;
    logic [47:0]        sv_mag;
    logic               we;
    logic signed [47:0] wr_sv;
    logic [63:0]        wr_sq;
    logic signed [48:0] s49;
    logic [64:0]        s65;
    logic [32:0]        c33;
    logic [30:0]        m16_mag;
    logic [61:0]        m16_sq;
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic signed [33:0] mo_t;
    logic [33:0]        mo_mag;
    logic signed [49:0] rv_t;
    logic [49:0]        rv_mag;
    logic signed [66:0] var67;
    logic [cmvn_pkg::DIV_W-1:0] m_q;
    logic               fin_load;
    logic               low_count;

    assign addr = cmvn_pkg::DIM_W'(r_cmd.dim);
    assign sv   = r_vld_rd ? r_sv_rd : 48'sd0;
    assign sq   = r_vld_rd ? r_sq_rd : 64'd0;
    assign low_count = !r_cmd.dim_ok || (r_count < cmvn_pkg::ONE_COUNT);
    assign o_pop = (r_state == S_IDLE) && !r_fin && i_cmd_valid;
    assign fin_load = r_fin && (!r_out_valid || !i_out_stall);

    always_comb begin
        sv_mag   = sv[47] ? 48'(~sv + 48'sd1) : sv;
        s49      = {sv[47], sv} + {{16{r_p1[32]}}, r_p1};
        s65      = {1'b0, sq} + {17'd0, r_p2};
        c33      = {1'b0, r_count} + {17'd0, r_cmd.weight};
        m16_mag  = r_m16[31] ? 31'(-r_m16) : r_m16[30:0];
        m16_sq   = m16_mag * m16_mag;
        diff     = {{10{r_cmd.feature[15]}}, r_cmd.feature, 8'd0} - {{2{r_m16[31]}}, r_m16};
        diff_mag = diff[33] ? 34'(-diff) : diff;
        mo_t     = i_cfg.reverse ? {{10{r_cmd.feature[15]}}, r_cmd.feature, 8'd0}
                                   + {{2{r_m16[31]}}, r_m16}
                                 : diff;
        mo_mag   = mo_t[33] ? 34'(-mo_t) : mo_t;
        rv_t     = {r_prod[48], r_prod} + {{10{r_m16[31]}}, r_m16, 8'd0};
        rv_mag   = rv_t[49] ? 50'(-rv_t) : rv_t;
        var67    = $signed({1'b0, i_div_quot}) - $signed({20'd0, r_msq});
        m_q      = (i_div_quot > cmvn_pkg::DIV_W'(cmvn_pkg::M16_MAX))
                   ? cmvn_pkg::DIV_W'(cmvn_pkg::M16_MAX) : i_div_quot;
    end

    // store write: fake unit stats or accumulate
    always_comb begin
        we    = 1'b0;
        wr_sv = '0;
        wr_sq = '0;
        if (r_state == S_DISP && r_cmd.kind == cmvn_pkg::K_FAKE && r_cmd.dim_ok) begin
            we    = 1'b1;
            wr_sq = {16'd0, r_count, 16'd0};
        end else if (r_state == S_ACC) begin
            we    = 1'b1;
            if (s49[48] != s49[47]) wr_sv = s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            else                    wr_sv = s49[47:0];
            wr_sq = s65[64] ? '1 : s65[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_sv[addr] <= wr_sv;
            mem_sq[addr] <= wr_sq;
        end
        r_sv_rd  <= mem_sv[addr];
        r_sq_rd  <= mem_sq[addr];
        r_vld_rd <= r_valid[addr];
    end

    // unit requests
    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = r_count;
        o_sqrt_start       = (r_state == S_VAR);
        o_sqrt_value       = {r_var, 16'd0};
        if (r_state == S_DISP && r_cmd.kind == cmvn_pkg::K_APPLY && !low_count) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = {10'd0, sv_mag, 8'd0} + cmvn_pkg::DIV_W'(r_count[31:1]);
        end else if (r_state == S_MSQ) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = {2'b00, sq} + cmvn_pkg::DIV_W'(r_count[31:1]);
        end else if (r_state == S_SDX && !i_cfg.reverse) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = cmvn_pkg::DIV_W'({diff_mag, 8'd0})
                                 + cmvn_pkg::DIV_W'(r_sd[31:1]);
            o_div_req.divisor  = r_sd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_pop) n_state = S_READ;
            S_READ: n_state = S_DISP;
            S_DISP: begin
                unique case (r_cmd.kind)
                    cmvn_pkg::K_ACC:   n_state = r_cmd.dim_ok ? S_MUL1 : S_IDLE;
                    cmvn_pkg::K_APPLY: n_state = low_count ? S_IDLE : S_MEAN;
                    cmvn_pkg::K_FAKE:  n_state = S_IDLE;
                    cmvn_pkg::K_CLEAR: n_state = S_IDLE;
                    default:           n_state = S_IDLE;
                endcase
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC:  n_state = S_IDLE;
            S_MEAN: if (i_div_done) n_state = i_cfg.scale_en ? S_MSQ : S_MO;
            S_MO:   n_state = S_IDLE;
            S_MSQ:  n_state = S_E2;
            S_E2:   if (i_div_done) n_state = S_VAR;
            S_VAR:  n_state = S_SD;
            S_SD:   if (i_sqrt_done) n_state = S_SDX;
            S_SDX:  n_state = i_cfg.reverse ? S_REV : S_FWD;
            S_REV:  n_state = S_IDLE;
            S_FWD:  if (i_div_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        unique case (r_state)
            S_DISP: begin
                r_neg        <= sv[47];
                r_res        <= r_cmd.feature;
                r_res_status <= low_count ? cmvn_pkg::ST_LOW : cmvn_pkg::ST_OK;
            end
            S_MUL1: begin
                r_p1 <= r_cmd.feature * $signed({1'b0, r_cmd.weight});
                r_xx <= 32'((r_cmd.feature[15] ? 17'(-r_cmd.feature) : 17'(r_cmd.feature))
                        * (r_cmd.feature[15] ? 17'(-r_cmd.feature) : 17'(r_cmd.feature)));
            end
            S_MUL2: r_p2 <= r_xx * r_cmd.weight;
            S_MEAN: if (i_div_done) r_m16 <= r_neg ? 32'(-m_q[31:0]) : m_q[31:0];
            S_MO:   r_res <= cmvn_pkg::sat16(mo_t[33],
                                 cmvn_pkg::DIV_W'((mo_mag + 34'd128) >> 8));
            S_MSQ:  r_msq <= 47'((64'(m16_sq) + 64'd32768) >> 16);
            S_E2: begin
                if (i_div_done) begin
                    if (var67 < 67'sd1) begin
                        r_var        <= 48'd1;
                        r_res_status <= cmvn_pkg::ST_FLOOR;
                    end else if (var67 > cmvn_pkg::VAR_CAP) begin
                        r_var <= 48'(cmvn_pkg::VAR_CAP);
                    end else begin
                        r_var <= var67[47:0];
                    end
                end
            end
            S_SD:   if (i_sqrt_done) r_sd <= i_sqrt_root;
            S_SDX: begin
                r_neg  <= diff[33];
                r_prod <= r_cmd.feature * $signed({1'b0, r_sd});
            end
            S_REV:  r_res <= cmvn_pkg::sat16(rv_t[49],
                                 cmvn_pkg::DIV_W'((rv_mag + 50'd32768) >> 16));
            S_FWD:  if (i_div_done) r_res <= cmvn_pkg::sat16(r_neg, i_div_quot);
            default: ;
        endcase
        if (fin_load) begin
            r_out_value  <= r_res;
            r_out_dim    <= r_cmd.dim;
            r_out_status <= r_res_status;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) r_valid[addr] <= 1'b1;
            if (r_state == S_DISP && r_cmd.kind == cmvn_pkg::K_CLEAR) begin
                r_valid <= '0;
                r_count <= '0;
            end
            if (r_state == S_ACC && r_cmd.dim == 6'd0)
                r_count <= c33[32] ? '1 : c33[31:0];
            // result ready to hand to the output register
            if ((r_state == S_DISP && r_cmd.kind == cmvn_pkg::K_APPLY && low_count)
                || r_state == S_MO || r_state == S_REV
                || (r_state == S_FWD && i_div_done))
                r_fin <= 1'b1;
            else if (fin_load)
                r_fin <= 1'b0;
            if (fin_load)         r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_norm_value    = r_out_value;
    assign o_out_dim_index = r_out_dim;
    assign o_status        = r_out_status;

endmodule

// ----- src/cepstral_mean_variance_norm_unit.sv -----
// Top level of the cepstral mean/variance normalizer: config registers and wiring.
// Depends on cmvn_pkg, cmvn_front, cmvn_div, cmvn_sqrt and cmvn_back.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries elements: accumulate,
//  apply, fake unit stats, clear all. A four-deep queue decouples the input
//  from the sequencer, so beats are taken while earlier ones are in work.
//  Only apply produces an output beat (o_out_valid / i_out_stall); it holds
//  until taken. The sequencer goes on until the next apply result is ready,
//  then waits; the queue fills and o_in_stall rises.
//  Work per element in the sequencer (pop to next pop) is set by the shared
//  radix-4 divider and the square-root unit:
//    clear / fake / accumulate and apply with low count use neither unit,
//    apply mean only uses one divide, apply with variance uses three divides
//    and one square root forward, two divides and one square root reverse.
//  Elements are handled one at a time.
//  Config (i_cfg_we, i_cfg_idx, i_cfg_data) must be written only while idle; the block does not enforce it.
//  Reset clears the stats (per-entry valid bits), the count, config and
//  both channels; no clearing pass is needed.
module cepstral_mean_variance_norm_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic [5:0]          i_dim_index,
    input  logic signed [15:0]  i_feature,
    input  logic [15:0]         i_weight,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_norm_value,
    output logic [5:0]          o_out_dim_index,
    output logic [1:0]          o_status
);

    cmvn_pkg::t_cfg     r_cfg;
    cmvn_pkg::t_cmd     cmd;
    logic               cmd_valid, cmd_pop;
    cmvn_pkg::t_div_req div_req;
    logic               div_busy, div_done;
    logic [cmvn_pkg::DIV_W-1:0] div_quot;
    logic               sqrt_start, sqrt_busy, sqrt_done;
    logic [63:0]        sqrt_value;
    logic [31:0]        sqrt_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmvn_pkg::CFG_SCALE_EN: r_cfg.scale_en <= i_cfg_data;
                cmvn_pkg::CFG_REVERSE:  r_cfg.reverse  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmvn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_dim_index (i_dim_index),
        .i_feature   (i_feature),
        .i_weight    (i_weight),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_pop       (cmd_pop)
    );

    cmvn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cmvn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sqrt_value),
        .o_busy  (sqrt_busy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    cmvn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cmd_valid     (cmd_valid),
        .o_pop           (cmd_pop),
        .i_cfg           (r_cfg),
        .o_div_req       (div_req),
        .i_div_done      (div_done),
        .i_div_quot      (div_quot),
        .o_sqrt_start    (sqrt_start),
        .o_sqrt_value    (sqrt_value),
        .i_sqrt_done     (sqrt_done),
        .i_sqrt_root     (sqrt_root),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_norm_value    (o_norm_value),
        .o_out_dim_index (o_out_dim_index),
        .o_status        (o_status)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty queue");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_busy && sqrt_busy))
        else $error("divider and square root busy together");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_req.start || sqrt_start) |-> (!div_busy && !sqrt_busy))
        else $error("unit started while busy");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !cmd_valid))
        else $error("reset left a beat pending");

endmodule
